/* design/maft_pkg.sv */
// ----------------------------------------------------------------------------
// maft_pkg
// shared types and constants for the mac address frequency table
// ----------------------------------------------------------------------------
package maft_pkg;

	localparam int MAC_W  = 48;
	localparam int HIT_W  = 32;
	localparam int SLOT_W = 6;
	localparam int FILL_W = 7;

	localparam logic [HIT_W-1:0] HIT_MAX = '1;

	// request kinds
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// table select on a read
	localparam logic TAB_SRC = 1'b0;
	localparam logic TAB_DST = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [MAC_W-1:0]  src_mac;
		logic [MAC_W-1:0]  dst_mac;
		logic              read_table;
		logic [SLOT_W-1:0] read_index;
	} maft_req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] src_slot;
		logic              src_new;
		logic              src_dropped;
		logic [SLOT_W-1:0] dst_slot;
		logic              dst_new;
		logic              dst_dropped;
		logic [MAC_W-1:0]  entry_mac;
		logic [HIT_W-1:0]  entry_hits;
		logic              entry_valid;
		logic [FILL_W-1:0] fill_level;
	} maft_rsp_t;

	// control from the top level to one lane
	typedef struct packed {
		logic              start;
		logic              ack;
		logic              op_read;
		logic [SLOT_W-1:0] rd_idx;
		logic [MAC_W-1:0]  mac;
	} maft_lane_req_t;

	// status and result from one lane
	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] slot;
		logic              is_new;
		logic              dropped;
		logic [MAC_W-1:0]  entry_mac;
		logic [HIT_W-1:0]  entry_hits;
		logic              entry_valid;
		logic [FILL_W-1:0] fill;
	} maft_lane_sts_t;

endpackage

/* design/maft_stream_if.sv */
// ----------------------------------------------------------------------------
// maft_stream_if
// valid/ready channel carrying one beat of payload
// ----------------------------------------------------------------------------
interface maft_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

/* design/maft_lane.sv */
// ----------------------------------------------------------------------------
// maft_lane
// one address table: sequential lookup, count update, append and entry read
// ----------------------------------------------------------------------------
module maft_lane #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  maft_pkg::maft_lane_req_t lreq,
	output maft_pkg::maft_lane_sts_t lsts
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > maft_pkg::SLOT_W) ? CNT_W : maft_pkg::SLOT_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_RD_ADDR = 3'd2;
	localparam logic [2:0] S_RD_DATA = 3'd3;
	localparam logic [2:0] S_DONE    = 3'd4;

	logic [2:0]                      state_q;
	logic [CNT_W-1:0]                used_q;
	logic [CNT_W-1:0]                issue_q;
	logic [maft_pkg::MAC_W-1:0]      mac_q;
	logic [maft_pkg::SLOT_W-1:0]     rd_idx_q;

	logic                            cmp_vld_s1;
	logic [IDX_W-1:0]                cmp_idx_s1;
	logic [maft_pkg::MAC_W-1:0]      rd_mac_s1;
	logic [maft_pkg::HIT_W-1:0]      rd_hit_s1;

	logic [maft_pkg::MAC_W-1:0]      mac_mem [DEPTH];
	logic [maft_pkg::HIT_W-1:0]      hit_mem [DEPTH];

	logic [maft_pkg::SLOT_W-1:0]     res_slot_q;
	logic                            res_new_q;
	logic                            res_drop_q;
	logic [maft_pkg::MAC_W-1:0]      res_mac_q;
	logic [maft_pkg::HIT_W-1:0]      res_hits_q;
	logic                            res_valid_q;

	logic                            issue_vld;
	logic                            hit;
	logic                            exhausted;
	logic                            room;
	logic [IDX_W-1:0]                mem_addr;
	logic                            we;
	logic [IDX_W-1:0]                wr_addr;
	logic [maft_pkg::HIT_W-1:0]      wr_hit;
	logic [maft_pkg::HIT_W-1:0]      hit_inc;
	logic [CMP_W-1:0]                rd_ext;
	logic                            entry_ok;

	assign issue_vld = (state_q == S_SCAN) && (issue_q < used_q);
	assign hit       = cmp_vld_s1 && (rd_mac_s1 == mac_q);
	assign exhausted = !cmp_vld_s1 && (issue_q == used_q);
	assign room      = used_q < CNT_W'(DEPTH);
	assign hit_inc   = (rd_hit_s1 == maft_pkg::HIT_MAX) ? rd_hit_s1
	                                                    : rd_hit_s1 + 32'd1;

	assign rd_ext   = CMP_W'(rd_idx_q);
	assign entry_ok = rd_ext < CMP_W'(used_q);
	assign mem_addr = (state_q == S_RD_ADDR) ? rd_ext[IDX_W-1:0] : issue_q[IDX_W-1:0];

	assign we      = (state_q == S_SCAN) && (hit || (exhausted && room));
	assign wr_addr = hit ? cmp_idx_s1 : used_q[IDX_W-1:0];
	assign wr_hit  = hit ? hit_inc : 32'd1;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			issue_q    <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue_vld;
			if (issue_vld) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (lreq.start) begin
						issue_q <= '0;
						state_q <= lreq.op_read ? S_RD_ADDR : S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_DONE;
					end else if (exhausted) begin
						if (room) begin
							used_q <= used_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (lreq.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and result capture
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= issue_q[IDX_W-1:0];
		if (state_q == S_IDLE && lreq.start) begin
			mac_q    <= lreq.mac;
			rd_idx_q <= lreq.rd_idx;
		end
		if (state_q == S_SCAN && hit) begin
			res_slot_q  <= maft_pkg::SLOT_W'(cmp_idx_s1);
			res_new_q   <= 1'b0;
			res_drop_q  <= 1'b0;
			res_mac_q   <= '0;
			res_hits_q  <= '0;
			res_valid_q <= 1'b0;
		end else if (state_q == S_SCAN && exhausted) begin
			res_slot_q  <= room ? maft_pkg::SLOT_W'(used_q) : '0;
			res_new_q   <= room;
			res_drop_q  <= !room;
			res_mac_q   <= '0;
			res_hits_q  <= '0;
			res_valid_q <= 1'b0;
		end else if (state_q == S_RD_DATA) begin
			res_slot_q  <= '0;
			res_new_q   <= 1'b0;
			res_drop_q  <= 1'b0;
			res_mac_q   <= entry_ok ? rd_mac_s1 : '0;
			res_hits_q  <= entry_ok ? rd_hit_s1 : '0;
			res_valid_q <= entry_ok;
		end
	end

	// table storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mac_mem[wr_addr] <= mac_q;
			hit_mem[wr_addr] <= wr_hit;
		end
		rd_mac_s1 <= mac_mem[mem_addr];
		rd_hit_s1 <= hit_mem[mem_addr];
	end

	assign lsts.done        = (state_q == S_DONE);
	assign lsts.slot        = res_slot_q;
	assign lsts.is_new      = res_new_q;
	assign lsts.dropped     = res_drop_q;
	assign lsts.entry_mac   = res_mac_q;
	assign lsts.entry_hits  = res_hits_q;
	assign lsts.entry_valid = res_valid_q;
	assign lsts.fill        = maft_pkg::FILL_W'(used_q);

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(DEPTH))
		else $error("fill count beyond table depth");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (used_q == $past(used_q) || used_q == $past(used_q) + CNT_W'(1)))
		else $error("fill count moved by more than one");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !lreq.ack) |=> (state_q == S_DONE))
		else $error("result dropped before acknowledge");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		lreq.start |-> (state_q == S_IDLE))
		else $error("start while lane busy");

	a_new_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !(res_new_q && res_drop_q))
		else $error("address both added and dropped");

endmodule

/* design/mac_address_frequency_table.sv */
// operation: an accepted record beat starts both lanes, each scanning its used
//   entries through its memory read port one entry per cycle until a hit or the
//   end of the used entries, then appending or dropping a miss; a read beat reads one index
// throughput: one beat in the lanes at a time; the next is accepted once both
//   lanes are done and the result has moved into the output register, which
//   waits while a held result is not taken by rsp.ready
// reset: fill counts clear at once, table memories are not cleared
// ----------------------------------------------------------------------------
// mac_address_frequency_table
// source and destination address tables with saturating hit counts
// ----------------------------------------------------------------------------
module mac_address_frequency_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	maft_stream_if.sink   req,
	maft_stream_if.source rsp
);

	// one busy flag: a beat is being worked on by the two lanes
	logic                       busy_q;
	logic                       op_q;
	logic                       tab_q;

	// output register, frees the lanes while the result waits downstream
	logic                       rsp_valid_q;
	maft_pkg::maft_rsp_t        rsp_data_q;

	maft_pkg::maft_lane_req_t   src_lreq;
	maft_pkg::maft_lane_req_t   dst_lreq;
	maft_pkg::maft_lane_sts_t   src_sts;
	maft_pkg::maft_lane_sts_t   dst_sts;
	maft_pkg::maft_rsp_t        merged;
	maft_pkg::maft_lane_sts_t   sel_sts;

	logic                       accept;
	logic                       out_free;
	logic                       load;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	// both lanes finished and the output register can take the result
	assign load     = busy_q && src_sts.done && dst_sts.done && out_free;

	assign req.ready = !busy_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// both lanes start together; on a read each reads its own table and
	// the merge keeps the one that was asked for
	always_comb begin
		src_lreq.start   = accept;
		src_lreq.ack     = load;
		src_lreq.op_read = (req.data.req_type == maft_pkg::REQ_READ);
		src_lreq.rd_idx  = req.data.read_index;
		src_lreq.mac     = req.data.src_mac;

		dst_lreq.start   = accept;
		dst_lreq.ack     = load;
		dst_lreq.op_read = (req.data.req_type == maft_pkg::REQ_READ);
		dst_lreq.rd_idx  = req.data.read_index;
		dst_lreq.mac     = req.data.dst_mac;
	end

	maft_lane #(
		.DEPTH (TABLE_DEPTH)
	) u_src_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.lreq   (src_lreq),
		.lsts   (src_sts)
	);

	maft_lane #(
		.DEPTH (TABLE_DEPTH)
	) u_dst_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.lreq   (dst_lreq),
		.lsts   (dst_sts)
	);

	// merge stage: record beats take both lookup outcomes and the source
	// fill level, read beats take the entry and fill level of the chosen table only
	assign sel_sts = (tab_q == maft_pkg::TAB_DST) ? dst_sts : src_sts;

	always_comb begin
		merged = '0;
		if (op_q == maft_pkg::REQ_RECORD) begin
			merged.src_slot    = src_sts.slot;
			merged.src_new     = src_sts.is_new;
			merged.src_dropped = src_sts.dropped;
			merged.dst_slot    = dst_sts.slot;
			merged.dst_new     = dst_sts.is_new;
			merged.dst_dropped = dst_sts.dropped;
			merged.fill_level  = src_sts.fill;
		end else begin
			merged.entry_mac   = sel_sts.entry_mac;
			merged.entry_hits  = sel_sts.entry_hits;
			merged.entry_valid = sel_sts.entry_valid;
			merged.fill_level  = sel_sts.fill;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.data.req_type;
			tab_q <= req.data.read_table;
		end
		if (load) begin
			rsp_data_q <= merged;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
		else $error("response beat changed while waiting");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready)
		else $error("request side open while lanes busy");

	a_lanes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!src_sts.done && !dst_sts.done))
		else $error("beat accepted while a lane holds a result");

endmodule
